FILE: hw/rtl/ufb_pkg.sv
// Types and constants shared by the UBX frame builder modules.
`default_nettype none

package ufb_pkg;

    // Item codes on the func field.
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // UBX sync characters.
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // One input item.
    typedef struct packed {
        logic        func;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } out_item_t;

    // Command kinds passed from the front end to the back end.
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } cmd_kind_t;

    // Classified command. data0 holds the class byte or the payload byte,
    // close is set when the command must finish with the checksum pair.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [15:0] length;
        logic        close;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ufb_front.sv
// Front end: accepts items, tracks the open frame and classifies each item.
`default_nettype none

module ufb_front
    import ufb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item_data,
    output cmd_t          cmd,
    output logic          cmd_push,
    input  wire logic     cmd_full
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic        take;
    logic        keep;
    logic        zero_len;
    logic        last_byte;

    assign full      = cmd_full;
    assign take      = push && !cmd_full;
    assign cmd_push  = take && keep;
    assign zero_len  = (item_data.payload_length == 16'h0000);
    assign last_byte = (bytes_left_reg == 16'h0001);

    // Classify the item and work out the frame state after it.
    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        keep            = 1'b0;
        cmd.kind        = CMD_START;
        cmd.data0       = item_data.msg_class;
        cmd.data1       = item_data.msg_id;
        cmd.length      = item_data.payload_length;
        cmd.close       = 1'b0;
        if (item_data.func == FUNC_START)
        begin
            // A start always begins a new frame and drops any unfinished one; a zero-length one closes it at once.
            keep      = 1'b1;
            cmd.close = zero_len;
            if (take)
            begin
                frame_open_next = !zero_len;
                bytes_left_next = item_data.payload_length;
            end
        end
        else
        begin
            // Payload bytes outside an open frame are dropped here.
            cmd.kind  = CMD_PAYLOAD;
            cmd.data0 = item_data.payload_byte;
            cmd.close = last_byte;
            keep      = frame_open_reg && (bytes_left_reg != 16'h0000);
            if (take && keep)
            begin
                bytes_left_next = bytes_left_reg - 16'h0001;
                if (last_byte)
                begin
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    // Frame tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ufb_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module ufb_cmd_fifo
    import ufb_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire cmd_t wr_cmd,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;

    // Pointer and occupancy updates, pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ufb_back.sv
// Back end: expands commands into frame bytes and keeps the Fletcher pair.
`default_nettype none

module ufb_back
    import ufb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire logic pop,
    output logic      empty,
    output out_item_t result_data
);

    // Position within the command at the queue head.
    typedef enum logic [2:0] {
        SEQ_HEAD,
        SEQ_SYNC2,
        SEQ_CLASS,
        SEQ_ID,
        SEQ_LEN_LO,
        SEQ_LEN_HI,
        SEQ_CK_A,
        SEQ_CK_B
    } seq_t;

    seq_t       seq_reg;
    seq_t       seq_next;
    logic [7:0] sum_a_reg;
    logic [7:0] sum_a_next;
    logic [7:0] sum_b_reg;
    logic [7:0] sum_b_next;
    logic       valid_reg;
    logic       valid_next;
    out_item_t  result_reg;
    out_item_t  result_next;

    logic       advance;
    logic       done;
    logic       fold_en;
    logic       clear_sums;
    logic [7:0] fold_byte;
    logic [7:0] fold_a;
    logic [7:0] fold_b;

    assign empty       = !valid_reg;
    assign result_data = result_reg;
    assign advance     = !cmd_empty && (!valid_reg || pop);
    assign cmd_pop     = advance && done;

    // Fletcher step: A += b, then B += A.
    assign fold_a = sum_a_reg + fold_byte;
    assign fold_b = sum_b_reg + fold_a;

    // Byte selection and sequencing for the current step.
    always_comb
    begin
        seq_next                = seq_reg;
        done                    = 1'b0;
        fold_en                 = 1'b0;
        clear_sums              = 1'b0;
        fold_byte               = cmd.data0;
        result_next.out_byte    = SYNC_ONE;
        result_next.last_of_run = 1'b0;
        result_next.frame_end   = 1'b0;
        case (seq_reg)
            SEQ_HEAD:
            begin
                if (cmd.kind == CMD_START)
                begin
                    result_next.out_byte = SYNC_ONE;
                    clear_sums           = 1'b1;
                    seq_next             = SEQ_SYNC2;
                end
                else
                begin
                    // Payload byte, followed by the checksum when it is the last one.
                    result_next.out_byte    = cmd.data0;
                    fold_en                 = 1'b1;
                    result_next.last_of_run = !cmd.close;
                    done                    = !cmd.close;
                    seq_next                = cmd.close ? SEQ_CK_A : SEQ_HEAD;
                end
            end
            SEQ_SYNC2:
            begin
                result_next.out_byte = SYNC_TWO;
                seq_next             = SEQ_CLASS;
            end
            SEQ_CLASS:
            begin
                result_next.out_byte = cmd.data0;
                fold_byte            = cmd.data0;
                fold_en              = 1'b1;
                seq_next             = SEQ_ID;
            end
            SEQ_ID:
            begin
                result_next.out_byte = cmd.data1;
                fold_byte            = cmd.data1;
                fold_en              = 1'b1;
                seq_next             = SEQ_LEN_LO;
            end
            SEQ_LEN_LO:
            begin
                result_next.out_byte = cmd.length[7:0];
                fold_byte            = cmd.length[7:0];
                fold_en              = 1'b1;
                seq_next             = SEQ_LEN_HI;
            end
            SEQ_LEN_HI:
            begin
                // A zero-length frame closes right after its header.
                result_next.out_byte    = cmd.length[15:8];
                fold_byte               = cmd.length[15:8];
                fold_en                 = 1'b1;
                result_next.last_of_run = !cmd.close;
                done                    = !cmd.close;
                seq_next                = cmd.close ? SEQ_CK_A : SEQ_HEAD;
            end
            SEQ_CK_A:
            begin
                result_next.out_byte = sum_a_reg;
                seq_next             = SEQ_CK_B;
            end
            SEQ_CK_B:
            begin
                result_next.out_byte    = sum_b_reg;
                result_next.last_of_run = 1'b1;
                result_next.frame_end   = 1'b1;
                done                    = 1'b1;
                seq_next                = SEQ_HEAD;
            end
            default:
            begin
                seq_next = SEQ_HEAD;
            end
        endcase
    end

    // Next values of the checksum pair and the output register.
    always_comb
    begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            if (clear_sums)
            begin
                sum_a_next = '0;
                sum_b_next = '0;
            end
            else if (fold_en)
            begin
                sum_a_next = fold_a;
                sum_b_next = fold_b;
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    // Sequencer state, checksum pair and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SEQ_HEAD;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                seq_reg    <= seq_next;
                result_reg <= result_next;
            end
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ubx_frame_builder_unit.sv
// Path: with the queues empty, an item is written into the command queue and then into the
// result register, after which its first result is on the result ports.
// Throughput: one payload item per cycle while pop is high and the queue has room; a start
// item gives 6 or 8 result bytes and a closing payload item 3, one result byte per cycle while pop is high.
// A CMD_DEPTH-entry command queue lets the input keep taking items during those bursts.
// Reset (rst_n low, asynchronous) empties the queues, closes any frame and clears the sums.
`default_nettype none

module ubx_frame_builder_unit
    import ufb_pkg::*;
#(
    parameter int CMD_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item_data,
    input  wire logic     pop,
    output logic          empty,
    output out_item_t     result_data
);

    cmd_t        front_cmd;
    logic        front_push;
    logic        fifo_full;
    cmd_t        head_cmd;
    logic        head_empty;
    logic        head_pop;

    // Item intake and classification.
    ufb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item_data (item_data),
        .cmd       (front_cmd),
        .cmd_push  (front_push),
        .cmd_full  (fifo_full)
    );

    // Command queue.
    ufb_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_push),
        .full   (fifo_full),
        .wr_cmd (front_cmd),
        .pop    (head_pop),
        .empty  (head_empty),
        .head   (head_cmd)
    );

    // Byte sequencer and checksum.
    ufb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (head_empty),
        .cmd         (head_cmd),
        .cmd_pop     (head_pop),
        .pop         (pop),
        .empty       (empty),
        .result_data (result_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/ufb_checker.sv
// Port-level checks on the UBX frame builder, bound to the top level.
`default_nettype none

module ufb_checker
    import ufb_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      pop,
    input wire logic      empty,
    input wire out_item_t result_data
);

    // A waiting result that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result_data))
        else $error("result changed while stalled");

    // The closing checksum byte is always the last byte of its item.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result_data.frame_end |-> result_data.last_of_run)
        else $error("frame end without last of run");

    // Bytes of one item follow without a gap.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !result_data.last_of_run |=> !empty)
        else $error("gap inside a run of results");

    // After a frame closes only a new frame can produce bytes.
    a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && result_data.frame_end |=> empty || result_data.out_byte == SYNC_ONE)
        else $error("byte after frame end is not a sync byte");

endmodule

bind ubx_frame_builder_unit ufb_checker u_ufb_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the UBX frame builder with its Fletcher checksum predictor.
`timescale 1ns / 100ps

module tb;
    import ufb_pkg::*;

    // With this few items left to send, both sides stop idling.
    localparam int TAIL_ITEMS = 30;
    localparam int RANDOM_ITEMS = 162;
    localparam int DRAIN_CYCLES = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item_data = '0;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t result_data;

    // Items waiting to be sent and bytes the block still owes us.
    in_item_t  cmd_queue[$];
    out_item_t due_bytes[$];

    // Predictor state: the running Fletcher pair and the open frame.
    logic [7:0]  fl_a = 8'h00;
    logic [7:0]  fl_b = 8'h00;
    logic [15:0] pay_left = 16'h0000;
    logic        in_frame = 1'b0;

    logic      cmd_taken = 1'b0;
    int        send_gap = 0;
    int        pop_gap = 0;
    int        fails = 0;
    out_item_t want;

    ubx_frame_builder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item_data   (item_data),
        .pop         (pop),
        .empty       (empty),
        .result_data (result_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_item_t frame_byte(input logic [7:0] b, input logic fin);
        out_item_t r;
        r.out_byte = b;
        r.last_of_run = 1'b0;
        r.frame_end = fin;
        return r;
    endfunction

    task automatic fold_byte(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endtask

    // Work out the bytes one accepted item produces and queue them up.
    task automatic build_frame_bytes(input in_item_t c);
        out_item_t run[$];
        logic      closing;
        closing = 1'b0;
        if (c.func == FUNC_START)
        begin
            fl_a = 8'h00;
            fl_b = 8'h00;
            run = {run, frame_byte(SYNC_ONE, 1'b0)};
            run = {run, frame_byte(SYNC_TWO, 1'b0)};
            run = {run, frame_byte(c.msg_class, 1'b0)};
            run = {run, frame_byte(c.msg_id, 1'b0)};
            run = {run, frame_byte(c.payload_length[7:0], 1'b0)};
            run = {run, frame_byte(c.payload_length[15:8], 1'b0)};
            fold_byte(c.msg_class);
            fold_byte(c.msg_id);
            fold_byte(c.payload_length[7:0]);
            fold_byte(c.payload_length[15:8]);
            if (c.payload_length == 16'h0000)
                closing = 1'b1;
            else
            begin
                in_frame = 1'b1;
                pay_left = c.payload_length;
            end
        end
        else if (in_frame && pay_left != 16'h0000)
        begin
            run = {run, frame_byte(c.payload_byte, 1'b0)};
            fold_byte(c.payload_byte);
            pay_left = pay_left - 16'd1;
            if (pay_left == 16'h0000)
                closing = 1'b1;
        end
        // Closing the frame appends the checksum pair.
        if (closing)
        begin
            run = {run, frame_byte(fl_a, 1'b0)};
            run = {run, frame_byte(fl_b, 1'b1)};
            in_frame = 1'b0;
            pay_left = 16'h0000;
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        due_bytes = {due_bytes, run};
    endtask

    // Builders for start and payload items; fields that do not apply carry noise.
    task automatic add_start(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len);
        in_item_t c;
        c.func = FUNC_START;
        c.msg_class = cls;
        c.msg_id = id;
        c.payload_length = len;
        c.payload_byte = 8'($urandom_range(255, 0));
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic add_data(input logic [7:0] b);
        in_item_t c;
        c.func = FUNC_PAYLOAD;
        c.msg_class = 8'($urandom_range(255, 0));
        c.msg_id = 8'($urandom_range(255, 0));
        c.payload_length = 16'($urandom_range(65535, 0));
        c.payload_byte = b;
        cmd_queue = {cmd_queue, c};
    endtask

    // Stimulus: a directed opening, then random frames with some noise.
    initial
    begin
        int sent_items;
        int pick;
        int len;
        int count;
        // A payload byte with no frame open is dropped.
        add_data(8'hFF);
        // Zero length frame closes at once.
        add_start(8'h00, 8'h00, 16'h0000);
        // Largest length, left open and then abandoned by a new start.
        add_start(8'hFF, 8'hFF, 16'hFFFF);
        add_data(8'h00);
        add_data(8'hFF);
        add_start(8'h06, 8'h01, 16'h0001);
        add_data(8'hAA);
        add_data(8'h55);
        add_start(8'h01, 8'h07, 16'h0003);
        add_data(8'h12);
        add_data(8'h34);
        add_data(8'hFE);
        add_start(8'h0A, 8'h04, 16'h0100);
        add_data(8'h80);
        // A zero length start abandons the open frame.
        add_start(8'h13, 8'h80, 16'h0000);
        add_start(8'h02, 8'h15, 16'h0002);
        add_data(8'hFF);
        add_data(8'hFF);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(9, 0);
            if (pick == 0)
            begin
                // Stray payload byte between items, dropped by the block unless an abandoned frame is still open.
                add_data(8'($urandom_range(255, 0)));
                sent_items = sent_items + 1;
            end
            else
            begin
                pick = $urandom_range(15, 0);
                if (pick == 0)
                begin
                    // Full-range length; the frame is abandoned after a few bytes.
                    len = $urandom_range(65535, 0);
                    count = $urandom_range(4, 0);
                end
                else if (pick < 3)
                begin
                    len = 0;
                    count = 0;
                end
                else
                begin
                    len = $urandom_range(8, 1);
                    count = ($urandom_range(7, 0) == 0) ? $urandom_range(len - 1, 0) : len;
                end
                add_start(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), 16'(len));
                repeat (count)
                    add_data(8'($urandom_range(255, 0)));
                sent_items = sent_items + 1 + count;
            end
        end
    end

    // Reset, then wait for the stream to drain and report.
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cmd_queue.size() != 0 || push)
            @(posedge clk);
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && due_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // Item driver: holds each item until it is taken, idles in random bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!push || cmd_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                push <= 1'b0;
            end
            else if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(5, 0) == 0)
            begin
                send_gap = $urandom_range(7, 0);
                push <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                item_data <= cmd_queue.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // Result reader: stalls in random bursts until the tail of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pop_gap > 0)
            begin
                pop_gap = pop_gap - 1;
                pop <= 1'b0;
            end
            else if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(5, 0) == 0)
            begin
                pop_gap = $urandom_range(7, 0);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Monitor: predict on each taken item, check each popped byte.
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
            build_frame_bytes(item_data);
        if (rst_n && pop && !empty)
        begin
            if (due_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %02h last_of_run %0b frame_end %0b",
                       result_data.out_byte, result_data.last_of_run, result_data.frame_end);
                fails = fails + 1;
            end
            else
            begin
                want = due_bytes.pop_front();
                if (result_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, result_data.out_byte);
                    fails = fails + 1;
                end
                if (result_data.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, result_data.last_of_run);
                    fails = fails + 1;
                end
                if (result_data.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b",
                           want.frame_end, result_data.frame_end);
                    fails = fails + 1;
                end
            end
        end
    end

endmodule

FILE: ubx_frame_builder_unit.f
hw/rtl/ufb_pkg.sv
hw/rtl/ufb_front.sv
hw/rtl/ufb_cmd_fifo.sv
hw/rtl/ufb_back.sv
hw/rtl/ubx_frame_builder_unit.sv
hw/rtl/ufb_checker.sv
sim/tb.sv
